### design/envelope_ramp_unit_core_macros.svh
// Assertion macros used by the envelope ramp unit checker
`ifndef ENVELOPE_RAMP_UNIT_CORE_MACROS_SVH
`define ENVELOPE_RAMP_UNIT_CORE_MACROS_SVH

// Check that cons holds in the cycle after ante
`define ERU_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("eru assertion failed");

// Check that cons holds in the same cycle as ante
`define ERU_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("eru assertion failed");

`endif

### design/eru_pkg.sv
// Types, codes and the step table of the envelope ramp unit
package eru_pkg;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_TICK  = 1'b1;

    localparam logic [1:0] CFG_AMP_BASE    = 2'd0;
    localparam logic [1:0] CFG_FILTER_BASE = 2'd1;
    localparam logic [1:0] CFG_SPT         = 2'd2;

    localparam logic [15:0] SELECT_BASE = 16'h0D00;
    localparam logic [15:0] AREA_SIZE   = 16'h0040;
    localparam logic [7:0]  INC_NONE    = 8'h00;
    localparam logic [7:0]  INC_JUMP    = 8'hFF;
    localparam logic [26:0] FALL_BIAS   = 27'd256;

    localparam logic [30:0] FRAC_Q30 [8] = '{
        31'd1073741824, 31'd1170923762, 31'd1276901417, 31'd1392470869,
        31'd1518500250, 31'd1655936265, 31'd1805811301, 31'd1969251188
    };

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } in_t;

    typedef struct packed {
        logic       landed_bank;
        logic [4:0] landed_slot;
        logic       last;
    } out_t;

    typedef enum logic [2:0] {
        CMD_SEL,
        CMD_INC,
        CMD_TGT,
        CMD_TICK,
        CMD_FLUSH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       bank;
        logic [4:0] slot;
        logic [7:0] data;
    } cmd_t;

    // Exponential step in Q.8 for a 7-bit rate code, rounded half up
    function automatic logic [26:0] step_base(input logic [6:0] k);
        logic [4:0]  sh;
        logic [31:0] f;
        sh = 5'd19 - {1'b0, k[6:3]};
        f  = {1'b0, FRAC_Q30[k[2:0]]} + (32'd1 << (sh - 5'd1));
        return 27'(f >> sh);
    endfunction

endpackage

### design/eru_fifo.sv
// Two-entry command queue between the decoder and the ramp engine
module eru_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  eru_pkg::cmd_t push_data,
    input  logic          pop,
    output eru_pkg::cmd_t pop_data,
    output logic          full,
    output logic          not_empty
);
    import eru_pkg::*;

    cmd_t       mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rptr_reg];

    // Store on push
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

### design/eru_front.sv
// Address decoder that classifies each input transfer into a command
module eru_front #(
    parameter int NUM_SLOTS = 32
) (
    input  logic          s_valid,
    output logic          s_ready,
    input  eru_pkg::in_t  s_data,
    input  logic [15:0]   amp_base,
    input  logic [15:0]   filter_base,
    input  logic          q_full,
    output logic          q_push,
    output eru_pkg::cmd_t q_data
);
    import eru_pkg::*;

    logic [15:0] amp_off;
    logic [15:0] flt_off;
    logic        sel_hit;
    logic        amp_hit;
    logic        flt_hit;
    logic [5:0]  area_off;
    logic        keep;

    assign s_ready = !q_full;
    assign amp_off = s_data.addr - amp_base;
    assign flt_off = s_data.addr - filter_base;
    assign sel_hit = (s_data.addr[15:6] == SELECT_BASE[15:6]) && !s_data.addr[0];
    assign amp_hit = (s_data.addr >= amp_base) && (amp_off < AREA_SIZE);
    assign flt_hit = (s_data.addr >= filter_base) && (flt_off < AREA_SIZE);

    // Classify the transfer; drop writes that hit nothing or a slot beyond NUM_SLOTS - 1
    always_comb begin
        area_off    = amp_hit ? amp_off[5:0] : flt_off[5:0];
        q_data.bank = !amp_hit;
        q_data.data = s_data.wdata;
        q_data.slot = area_off[5:1];
        q_data.kind = area_off[0] ? CMD_TGT : CMD_INC;
        keep        = 1'b0;
        if (s_data.op == OP_TICK) begin
            q_data.kind = CMD_TICK;
            keep        = 1'b1;
        end else if (sel_hit) begin
            q_data.kind = CMD_SEL;
            q_data.slot = s_data.addr[5:1];
            keep        = ({1'b0, s_data.addr[5:1]} < 6'(NUM_SLOTS));
        end else if (amp_hit || flt_hit) begin
            keep = ({1'b0, area_off[5:1]} < 6'(NUM_SLOTS));
        end
    end

    assign q_push = s_valid && s_ready && keep;
endmodule

### design/eru_back.sv
// Ramp engine: sequencer, entry memory and read-multiply-update pipeline
module eru_back #(
    parameter int NUM_SLOTS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  eru_pkg::cmd_t q_data,
    output logic          q_pop,
    input  logic [15:0]   spt,
    output logic          m_valid,
    input  logic          m_ready,
    output eru_pkg::out_t m_data
);
    import eru_pkg::*;

    typedef struct packed {
        logic [7:0]  inc_b;
        logic [7:0]  tgt_b;
        logic [7:0]  goal_b;
        logic [7:0]  rinc;
        logic        run;
        logic [33:0] level;
    } rec_t;

    typedef enum logic [1:0] {ST_IDLE, ST_TICK, ST_FLUSH, ST_WAIT} state_t;

    state_t     state_reg;
    logic       cnt_bank_reg;
    logic [4:0] cnt_slot_reg;

    rec_t       mem [64];
    logic [63:0] vld_reg;
    logic [31:0] sel_reg;

    logic       adv;
    logic       iss_v;
    cmd_t       iss;

    logic       s1_v_reg;
    cmd_t       s1_reg;
    rec_t       rd_reg;
    logic       rd_vld_reg;
    logic       s2_v_reg;
    cmd_t       s2_reg;
    rec_t       s2_rec_reg;
    logic [34:0] s2_delta_reg;

    rec_t       rec1;
    logic [26:0] step1;
    logic [42:0] prod1;

    rec_t       new_rec;
    logic       we;
    logic       land;
    logic [33:0] goal;
    logic [33:0] tgoal;
    logic       arrived;

    logic       out_v_reg;
    out_t       out_reg;
    logic       pend_v_reg;
    logic       pend_bank_reg;
    logic [4:0] pend_slot_reg;

    assign adv     = !out_v_reg || m_ready;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    // Issue at most one pipeline operation per cycle, none while the result side stalls
    always_comb begin
        iss_v = 1'b0;
        q_pop = 1'b0;
        iss   = q_data;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && adv) begin
                    iss_v = 1'b1;
                    q_pop = 1'b1;
                    if (q_data.kind == CMD_TICK) begin
                        iss.bank = 1'b0;
                        iss.slot = 5'd0;
                    end
                end
            end
            ST_TICK: begin
                iss_v     = adv;
                iss.kind  = CMD_TICK;
                iss.bank  = cnt_bank_reg;
                iss.slot  = cnt_slot_reg;
            end
            ST_FLUSH: begin
                iss_v    = adv;
                iss.kind = CMD_FLUSH;
            end
            ST_WAIT: begin
                iss_v = 1'b0;
            end
            default: begin
                iss_v = 1'b0;
            end
        endcase
    end

    // Sequencer state and entry counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_bank_reg <= 1'b0;
            cnt_slot_reg <= 5'd0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        if (q_data.kind == CMD_TICK) begin
                            if (NUM_SLOTS == 1) begin
                                cnt_bank_reg <= 1'b1;
                                cnt_slot_reg <= 5'd0;
                            end else begin
                                cnt_bank_reg <= 1'b0;
                                cnt_slot_reg <= 5'd1;
                            end
                            state_reg <= ST_TICK;
                        end else begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_TICK: begin
                    if (adv) begin
                        if (cnt_slot_reg == 5'(NUM_SLOTS - 1)) begin
                            cnt_slot_reg <= 5'd0;
                            cnt_bank_reg <= 1'b1;
                            if (cnt_bank_reg) begin
                                state_reg <= ST_FLUSH;
                            end
                        end else begin
                            cnt_slot_reg <= cnt_slot_reg + 5'd1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (adv) begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (!s1_v_reg && !s2_v_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Read the entry memory
    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_reg     <= mem[{iss.bank, iss.slot}];
            rd_vld_reg <= vld_reg[{iss.bank, iss.slot}];
            s1_reg     <= iss;
        end
    end

    // Form the tick delta from the stored rate code
    always_comb begin
        rec1  = rd_vld_reg ? rd_reg : '0;
        step1 = step_base(rec1.rinc[6:0]) + (rec1.rinc[7] ? FALL_BIAS : 27'd0);
        prod1 = step1 * spt;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg       <= s1_reg;
            s2_rec_reg   <= rec1;
            s2_delta_reg <= prod1[42:8];
        end
    end

    // Update one entry
    always_comb begin
        new_rec = s2_rec_reg;
        we      = 1'b0;
        land    = 1'b0;
        arrived = 1'b0;
        goal    = {s2_rec_reg.goal_b, 26'd0};
        tgoal   = {s2_reg.data, 26'd0};
        case (s2_reg.kind)
            CMD_INC: begin
                new_rec.inc_b = s2_reg.data;
                we            = 1'b1;
            end
            CMD_TGT: begin
                new_rec.tgt_b = s2_reg.data;
                we            = 1'b1;
                if (sel_reg[s2_reg.slot] == s2_reg.bank) begin
                    new_rec.goal_b = s2_reg.data;
                    new_rec.rinc   = s2_rec_reg.inc_b;
                    new_rec.run    = 1'b0;
                    if (s2_rec_reg.inc_b == INC_NONE) begin
                        new_rec.run = 1'b0;
                    end else if (s2_rec_reg.inc_b == INC_JUMP) begin
                        new_rec.level = tgoal;
                    end else if ((s2_rec_reg.inc_b[7] && s2_rec_reg.level <= tgoal) ||
                                 (!s2_rec_reg.inc_b[7] && s2_rec_reg.level >= tgoal)) begin
                        new_rec.level = tgoal;
                        land          = 1'b1;
                    end else begin
                        new_rec.run = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                if (s2_rec_reg.run) begin
                    we = 1'b1;
                    if (s2_rec_reg.rinc[7]) begin
                        arrived = (s2_rec_reg.level <= goal) ||
                                  ({1'b0, s2_rec_reg.level - goal} <= s2_delta_reg);
                        new_rec.level = s2_rec_reg.level - s2_delta_reg[33:0];
                    end else begin
                        arrived = (s2_rec_reg.level >= goal) ||
                                  ({1'b0, goal - s2_rec_reg.level} <= s2_delta_reg);
                        new_rec.level = s2_rec_reg.level + s2_delta_reg[33:0];
                    end
                    if (arrived) begin
                        new_rec.level = goal;
                        new_rec.run   = 1'b0;
                        land          = 1'b1;
                    end
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Write back the entry
    always_ff @(posedge aclk) begin
        if (adv && s2_v_reg && we) begin
            mem[{s2_reg.bank, s2_reg.slot}] <= new_rec;
        end
    end

    // Pipeline valids, entry valid bits, bank selects and the result path
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            vld_reg    <= '0;
            sel_reg    <= '0;
            out_v_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg  <= iss_v;
            s2_v_reg  <= s1_v_reg;
            out_v_reg <= 1'b0;
            if (s2_v_reg && we) begin
                vld_reg[{s2_reg.bank, s2_reg.slot}] <= 1'b1;
            end
            if (s2_v_reg && s2_reg.kind == CMD_SEL) begin
                sel_reg[s2_reg.slot] <= s2_reg.data[7];
            end
            if (s2_v_reg && land) begin
                if (pend_v_reg) begin
                    out_v_reg <= 1'b1;
                    out_reg   <= '{landed_bank: pend_bank_reg,
                                   landed_slot: pend_slot_reg, last: 1'b0};
                end
                pend_v_reg    <= 1'b1;
                pend_bank_reg <= s2_reg.bank;
                pend_slot_reg <= s2_reg.slot;
            end else if (s2_v_reg && s2_reg.kind == CMD_FLUSH && pend_v_reg) begin
                out_v_reg  <= 1'b1;
                out_reg    <= '{landed_bank: pend_bank_reg,
                                landed_slot: pend_slot_reg, last: 1'b1};
                pend_v_reg <= 1'b0;
            end
        end
    end
endmodule

### design/envelope_ramp_unit_core.sv
// Envelope ramp unit: 2 banks of NUM_SLOTS ramps driven by register writes and ticks
// A tick holds the engine while it walks every entry, one entry per cycle unless results stall, through the read,
// multiply and update pipeline, then a drain that marks its last landing. A write holds the engine for one pass
// through the same pipeline. Result stalls lengthen both; two commands can wait in the queue meanwhile.
// Reset (aresetn low, synchronous) restores the register defaults and clears every
// ramp entry through per-entry valid bits, with no clearing pass.
module envelope_ramp_unit_core #(
    parameter int NUM_SLOTS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  eru_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output eru_pkg::out_t m_data,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata
);
    import eru_pkg::*;

    logic [15:0] amp_base_reg;
    logic [15:0] filter_base_reg;
    logic [15:0] spt_reg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_nonempty;
    cmd_t        q_in;
    cmd_t        q_out;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_base_reg    <= 16'd3584;
            filter_base_reg <= 16'd3648;
            spt_reg         <= 16'd2621;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_AMP_BASE:    amp_base_reg    <= cfg_wdata;
                CFG_FILTER_BASE: filter_base_reg <= cfg_wdata;
                CFG_SPT:         spt_reg         <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    eru_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .amp_base    (amp_base_reg),
        .filter_base (filter_base_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    eru_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .not_empty (q_nonempty)
    );

    eru_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_nonempty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .spt     (spt_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

### design/eru_checker.sv
// Port-level checks of the envelope ramp unit and their binding
`include "envelope_ramp_unit_core_macros.svh"

module eru_checker #(
    parameter int NUM_SLOTS = 32
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input eru_pkg::out_t m_data
);
    // Stalled result transfer holds its payload
    `ERU_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // Reset empties the result side
    `ERU_ASSERT_NEXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_valid)
    // Reported slot is one that exists
    `ERU_ASSERT_NOW(a_slot_range, aclk, !aresetn, m_valid, m_data.landed_slot < NUM_SLOTS)
endmodule

bind envelope_ramp_unit_core eru_checker #(.NUM_SLOTS(NUM_SLOTS)) u_eru_checker (.*);

### tb/tb_envelope_ramp_unit_core.sv
// Self-checking testbench for the envelope ramp unit: writes and ticks against a predictor
module tb_envelope_ramp_unit_core;
    timeunit 1ns;
    timeprecision 1ps;

    import eru_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int MAX_REPORTS    = 10;

    // 2^(j/8) scaled by 2^30
    localparam longint unsigned EXP_FRAC [8] = '{
        64'd1073741824, 64'd1170923762, 64'd1276901417, 64'd1392470869,
        64'd1518500250, 64'd1655936265, 64'd1805811301, 64'd1969251188
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    // Predictor state
    logic [15:0] amp_base_q;
    logic [15:0] filter_base_q;
    logic [15:0] spt_q;
    logic        bank_sel   [32];
    logic [7:0]  tgt_byte   [64];
    logic [7:0]  inc_byte   [64];
    logic [33:0] level      [64];
    logic [26:0] step_q8    [64];
    logic [33:0] goal       [64];
    logic        falling    [64];
    logic        running    [64];

    out_t landings [$];
    int   errors;
    int   mismatches;
    int   stall_left;
    int   idle_cycles;
    bit   calm;

    envelope_ramp_unit_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Step in Q.8 for an increment byte
    function automatic logic [26:0] rate_step(input logic [7:0] inc);
        int unsigned     k;
        int unsigned     sh;
        longint unsigned s;
        k  = inc[6:0];
        sh = 19 - (k >> 3);
        s  = (EXP_FRAC[k % 8] + (64'd1 << (sh - 1))) >> sh;
        if (inc[7]) s += 256;
        return s[26:0];
    endfunction

    function automatic void reset_predictor();
        amp_base_q    = 16'd3584;
        filter_base_q = 16'd3648;
        spt_q         = 16'd2621;
        for (int i = 0; i < 64; i++) begin
            if (i < 32) bank_sel[i] = 1'b0;
            tgt_byte[i] = '0;
            inc_byte[i] = '0;
            level[i]    = '0;
            step_q8[i]  = '0;
            goal[i]     = '0;
            falling[i]  = 1'b0;
            running[i]  = 1'b0;
        end
    endfunction

    function automatic void push_landing(input logic bank, input logic [4:0] slot,
                                         input logic fin);
        out_t r;
        r.landed_bank = bank;
        r.landed_slot = slot;
        r.last        = fin;
        landings.insert(landings.size(), r);
    endfunction

    // Load a ramp from its bytes; return 1 when it lands at once
    function automatic bit launch_ramp(input int idx);
        logic [7:0] inc;
        inc          = inc_byte[idx];
        step_q8[idx] = (inc == INC_NONE) ? 27'd0 : rate_step(inc);
        falling[idx] = inc[7];
        goal[idx]    = {tgt_byte[idx], 26'd0};
        running[idx] = (inc != INC_NONE);
        if (!running[idx]) return 0;
        if (inc == INC_JUMP) begin
            level[idx]   = goal[idx];
            running[idx] = 1'b0;
            return 0;
        end
        if ((falling[idx] && level[idx] <= goal[idx]) ||
            (!falling[idx] && level[idx] >= goal[idx])) begin
            level[idx]   = goal[idx];
            running[idx] = 1'b0;
            return 1;
        end
        return 0;
    endfunction

    function automatic void predict_write(input logic [15:0] addr, input logic [7:0] data);
        int unsigned a;
        int unsigned off;
        int unsigned slot;
        int          bank;
        int          idx;
        a = addr;
        if (a >= SELECT_BASE && a < SELECT_BASE + AREA_SIZE && !a[0]) begin
            bank_sel[(a - SELECT_BASE) >> 1] = data[7];
            return;
        end
        if (a >= amp_base_q && a - amp_base_q < AREA_SIZE) begin
            bank = 0;
            off  = a - amp_base_q;
        end else if (a >= filter_base_q && a - filter_base_q < AREA_SIZE) begin
            bank = 1;
            off  = a - filter_base_q;
        end else begin
            return;
        end
        slot = off >> 1;
        idx  = bank * 32 + slot;
        if (off[0]) begin
            tgt_byte[idx] = data;
            if (bank_sel[slot] == bank[0] && launch_ramp(idx))
                push_landing(bank[0], slot[4:0], 1'b1);
        end else begin
            inc_byte[idx] = data;
        end
    endfunction

    function automatic void predict_tick();
        longint unsigned delta;
        longint unsigned lv;
        longint unsigned gl;
        bit              arrived;
        int              landed [$];
        for (int i = 0; i < 64; i++) begin
            if (!running[i]) continue;
            delta = (longint'(step_q8[i]) * longint'(spt_q)) >> 8;
            lv    = level[i];
            gl    = goal[i];
            if (falling[i]) begin
                arrived = (lv <= gl) || (lv - gl <= delta);
                if (!arrived) lv -= delta;
            end else begin
                arrived = (lv >= gl) || (gl - lv <= delta);
                if (!arrived) lv += delta;
            end
            if (!arrived) begin
                level[i] = lv[33:0];
                continue;
            end
            level[i]   = goal[i];
            running[i] = 1'b0;
            landed.insert(landed.size(), i);
        end
        foreach (landed[n])
            push_landing(1'(landed[n] / 32), 5'(landed[n] % 32), n == landed.size() - 1);
    endfunction

    // Send one item; expectations are queued before it goes out
    task automatic send_item(input logic op, input logic [15:0] addr, input logic [7:0] data);
        in_t it;
        int  gap;
        it.op    = op;
        it.addr  = addr;
        it.wdata = data;
        if (op == OP_TICK) predict_tick();
        else predict_write(addr, data);
        gap = calm ? 0 : $urandom_range(0, 17);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic write_reg(input logic [15:0] addr, input logic [7:0] data);
        send_item(OP_WRITE, addr, data);
    endtask

    task automatic tick();
        send_item(OP_TICK, 16'($urandom), 8'($urandom));
    endtask

    // Drain results and let the engine finish before touching registers
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (landings.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_reg(input logic [1:0] index, input logic [15:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            CFG_AMP_BASE:    amp_base_q    = value;
            CFG_FILTER_BASE: filter_base_q = value;
            CFG_SPT:         spt_q         = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Bank area address of one ramp byte
    function automatic logic [15:0] ramp_addr(input logic bank, input int slot, input bit tgt);
        return (bank ? filter_base_q : amp_base_q) + 16'(slot * 2) + 16'(tgt);
    endfunction

    task automatic arm_ramp(input logic bank, input int slot, input logic [7:0] inc,
                            input logic [7:0] tgt);
        write_reg(SELECT_BASE + 16'(slot * 2), {bank, 7'h00});
        write_reg(ramp_addr(bank, slot, 0), inc);
        write_reg(ramp_addr(bank, slot, 1), tgt);
    endtask

    // Zero and jump increments, immediate landing, select decoding, stray addresses
    task automatic test_special_cases();
        arm_ramp(1'b0, 0, INC_NONE, 8'h40);
        arm_ramp(1'b0, 1, INC_JUMP, 8'hFF);
        arm_ramp(1'b0, 2, 8'h10, 8'h00);
        arm_ramp(1'b1, 31, 8'hF0, 8'h00);
        write_reg(SELECT_BASE + 16'd1, 8'h80);
        write_reg(ramp_addr(1'b1, 3, 1), 8'h22);
        write_reg(16'h0000, 8'hFF);
        write_reg(16'hFFFF, 8'h00);
        tick();
    endtask

    // Fast rising and falling ramps that land over a few ticks
    task automatic test_landings();
        arm_ramp(1'b0, 5, 8'h7F, 8'hFF);
        arm_ramp(1'b1, 0, 8'h7E, 8'h80);
        arm_ramp(1'b0, 1, 8'hFE, 8'h00);
        arm_ramp(1'b1, 31, 8'h70, 8'h01);
        repeat (6) tick();
    endtask

    // Mostly well-formed ramp setups with ticks between, some noise
    task automatic test_random(input int count);
        int    sent;
        int    pick;
        int    slot;
        logic  bank;
        sent = 0;
        while (sent < count) begin
            if (sent % 25 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, 31);
            bank = 1'($urandom_range(0, 1));
            if (pick < 30) begin
                tick();
                sent++;
            end else if (pick < 80) begin
                arm_ramp(bank, slot,
                         ($urandom_range(0, 3) != 0) ? 8'($urandom_range(96, 127)) |
                                                         8'($urandom_range(0, 1) << 7)
                                                     : 8'($urandom),
                         8'($urandom));
                sent += 3;
            end else if (pick < 90) begin
                write_reg(ramp_addr(bank, slot, 1'($urandom_range(0, 1))), 8'($urandom));
                sent++;
            end else begin
                write_reg(16'($urandom), 8'($urandom));
                sent++;
            end
        end
        calm = 0;
    endtask

    // Register settings: moved and overlapping bases, tick scale extremes
    task automatic test_settings();
        set_reg(CFG_SPT, 16'hFFFF);
        test_random(30);
        set_reg(CFG_AMP_BASE, 16'hFFC0);
        set_reg(CFG_FILTER_BASE, 16'h0000);
        test_random(30);
        set_reg(CFG_AMP_BASE, SELECT_BASE);
        set_reg(CFG_FILTER_BASE, 16'hFFFF);
        set_reg(CFG_SPT, 16'h0000);
        test_random(15);
        set_reg(CFG_SPT, 16'h0001);
        test_random(10);
        set_reg(CFG_AMP_BASE, 16'($urandom));
        set_reg(CFG_FILTER_BASE, 16'($urandom));
        set_reg(CFG_SPT, 16'($urandom_range(1024, 65535)));
        test_random(30);
    endtask

    // Hold result-side stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expected landing
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (landings.size() == 0) begin
                errors++;
                if (mismatches < MAX_REPORTS)
                    $display("unexpected landing bank %0d slot %0d last %0d",
                             m_data.landed_bank, m_data.landed_slot, m_data.last);
                mismatches++;
            end else begin
                want = landings[0];
                landings.delete(0);
                if (m_data !== want) begin
                    errors++;
                    if (mismatches < MAX_REPORTS)
                        $display({"landing mismatch: expected bank %0d slot %0d last %0d,",
                                  " got bank %0d slot %0d last %0d"},
                                 want.landed_bank, want.landed_slot, want.last,
                                 m_data.landed_bank, m_data.landed_slot, m_data.last);
                    mismatches++;
                end
            end
            stall_left = calm ? 0 : $urandom_range(0, 17);
        end
    end

    // Count cycles with no transfer of any kind
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_AMP_BASE;
        cfg_wdata  = '0;
        errors     = 0;
        mismatches = 0;
        stall_left = 0;
        idle_cycles = 0;
        calm       = 0;
        reset_predictor();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_special_cases();
        test_landings();
        test_random(20);
        test_settings();

        wait_idle();
        if (landings.size() != 0) errors++;
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
